// ===== rtl/ctc_greedy_decoder_unit_macros.svh =====
// Assertion macros shared by the CTC greedy decoder RTL
`ifndef CTC_GREEDY_DECODER_UNIT_MACROS_SVH
`define CTC_GREEDY_DECODER_UNIT_MACROS_SVH

// Implication checked every clock outside reset
`define CTC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked on the next clock outside reset
`define CTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ctc_pkg.sv =====
// Package: constants, exponential table and helper types for the CTC decoder
`timescale 1ns / 1ps
`default_nettype none
package ctc_pkg;
   localparam int MAX_ALPHABET    = 128;
   localparam int MAX_RUN         = 1024;
   localparam int EXP_TABLE_DEPTH = 256;
   localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
   localparam int RUN_W           = 11;
   localparam int ACC_W           = 24;
   localparam int TOT_W           = 26;
   localparam logic [7:0] NONE_MARK = 8'h80;
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   // Divider request: numerator / denominator, numerator pre-biased for rounding
   typedef struct packed {
      logic        start;
      logic [33:0] numer;
      logic [25:0] denom;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [33:0] quot;
   } div_rsp_type;

   // Truncating long division of a nonnegative value by a small positive number
   function automatic longint div_small(input longint n, input longint k);
      longint q, r;
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         r = (r <<< 1) | ((n >>> b) & longint'(1));
         q = q <<< 1;
         if (r >= k) begin
            r = r - k;
            q = q | longint'(1);
         end
      end
      return q;
   endfunction

   // exp(-16*i/EXP_TABLE_DEPTH) in Q1.16: Taylor series, then squared four times
   function automatic logic [16:0] exp_entry(input int i);
      longint u, term, sum;
      u = (longint'(i) <<< 30) >>> EXP_IDX_W;
      term = longint'(1) <<< 30;
      sum = term;
      for (int k = 1; k <= 16; k++) begin
         term = div_small((term * u) >>> 30, longint'(k));
         sum = ((k & 1) == 1) ? sum - term : sum + term;
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) <<< 30)) sum = longint'(1) <<< 30;
      for (int s = 0; s < 4; s++) sum = (sum * sum + (longint'(1) <<< 29)) >>> 30;
      return 17'((sum + (1 <<< 13)) >>> 14);
   endfunction
endpackage
`default_nettype wire

// ===== rtl/ctc_stream_if.sv =====
// Valid/ready stream interfaces for logits and decoded items
`timescale 1ns / 1ps
`default_nettype none
interface ctc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] logit_value;
   logic               end_of_sequence;
   modport source (output valid, logit_value, end_of_sequence, input ready);
   modport sink   (input valid, logit_value, end_of_sequence, output ready);
endinterface

interface ctc_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  char_index;
   logic        has_char;
   logic [15:0] confidence;
   logic        end_of_text;
   modport source (output valid, char_index, has_char, confidence, end_of_text,
                   input ready);
   modport sink   (input valid, char_index, has_char, confidence, end_of_text,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/ctc_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle; truncates, so callers pre-bias to round to nearest
`timescale 1ns / 1ps
`default_nettype none
module ctc_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctc_pkg::div_req_type req,
   output      ctc_pkg::div_rsp_type rsp
);
   import ctc_pkg::*;
   `include "ctc_greedy_decoder_unit_macros.svh"

   logic [33:0] num_ff, num_in;
   logic [33:0] quo_ff, quo_in;
   logic [26:0] rem_ff, rem_in;
   logic [25:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [26:0] trial;

   // numerator is pre-biased by half the denominator by the caller
   always_comb begin
      num_in = num_ff; quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[25:0], num_ff[33]};
      if (req.start) begin
         num_in = req.numer; den_in = req.denom; rem_in = '0;
         quo_in = '0; cnt_in = 6'd34; busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[32:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[32:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[32:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      num_ff <= num_in; quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

   `CTC_ASSERT_NEXT(a_div_done, clock, reset, busy_ff && cnt_ff == 6'd1, done_ff, "divider done missing")
   `CTC_ASSERT_IMP(a_div_count, clock, reset, !busy_ff, !done_in || req.start, "divider done while idle")
   `CTC_ASSERT_IMP(a_div_busy, clock, reset, busy_ff, cnt_ff != 6'd0, "divider counter underflow")
endmodule
`default_nettype wire

// ===== rtl/ctc_greedy_decoder_unit.sv =====
// Top level: streaming CTC greedy decoder with online softmax
//  channel | dir | handshake      | payload
//  req     | in  | valid/ready    | logit_value, end_of_sequence
//  rsp     | out | valid/ready    | char_index, has_char, confidence, end_of_text
//  csr     | in  | write enable   | alphabet_count
// Each logit inside a row passes the accept, exp lookup and multiply-add states in turn.
// At a row end one reciprocal runs on the shared divider (34 steps); closing a run
// uses the divider again for the mean, and end of sequence may add a third.
// Reset is synchronous and clears all control state; no clearing pass.
// A new result waits until the output register is free; the block stalls meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module ctc_greedy_decoder_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   ctc_req_if.sink     req,
   ctc_rsp_if.source   rsp,
   input  wire logic   csr_write_enable,
   input  wire logic [7:0] csr_write_data
);
   import ctc_pkg::*;
   `include "ctc_greedy_decoder_unit_macros.svh"

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EXP   = 4'd1;
   localparam logic [3:0] S_MAC   = 4'd2;
   localparam logic [3:0] S_RECIP = 4'd3;
   localparam logic [3:0] S_RWAIT = 4'd4;
   localparam logic [3:0] S_RUN   = 4'd5;
   localparam logic [3:0] S_MEAN  = 4'd6;
   localparam logic [3:0] S_MWAIT = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;
   localparam logic [3:0] S_EOS   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [7:0]  count_ff;
   logic signed [15:0] best_ff, best_in;
   logic [6:0]  cls_ff, cls_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [6:0]  pos_ff, pos_in;
   logic [7:0]  prev_ff, prev_in;
   logic [TOT_W-1:0] tot_ff, tot_in;
   logic [RUN_W-1:0] len_ff, len_in;
   logic signed [15:0] x_ff, x_in;
   logic        eos_ff, eos_in;
   logic        gt_ff, gt_in;
   logic [16:0] e_ff, e_in;
   logic [15:0] prob_ff, prob_in;
   logic        second_ff, second_in;   // flush due after the run change
   logic        emitted_ff, emitted_in;
   logic        ov_ff, ov_in;
   logic [6:0]  oc_ff, oc_in;
   logic        oh_ff, oh_in;
   logic [15:0] oconf_ff, oconf_in;
   logic        oe_ff, oe_in;
   logic [16:0] exp_rom [EXP_TABLE_DEPTH];
   logic [16:0] d;
   logic [17:0] idx_full;
   logic [7:0]  count_eff;
   logic [41:0] prod;
   logic [25:0] scaled;
   logic [24:0] sum_add;
   logic        have_run;
   div_req_type dreq;
   div_rsp_type drsp;

   always_comb begin
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) exp_rom[i] = exp_entry(i);
   end

   ctc_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // clamp of the class count
   always_comb begin
      if (count_ff < 8'd2) count_eff = 8'd2;
      else if (count_ff > 8'(MAX_ALPHABET)) count_eff = 8'(MAX_ALPHABET);
      else count_eff = count_ff;
   end

   assign d = gt_ff ? 17'(32'(x_ff) - 32'(best_ff)) : 17'(32'(best_ff) - 32'(x_ff));
   assign idx_full = 18'((d + 17'd8) >> 4);
   assign prod = 42'(acc_ff) * 42'(e_ff);
   assign scaled = 26'((prod + 42'd32768) >> 16);
   assign have_run = prev_ff != NONE_MARK && prev_ff != 8'd0 && len_ff != '0;

   always_comb begin
      state_in = state_ff; best_in = best_ff; cls_in = cls_ff; acc_in = acc_ff;
      pos_in = pos_ff; prev_in = prev_ff; tot_in = tot_ff; len_in = len_ff;
      x_in = x_ff; eos_in = eos_ff; gt_in = gt_ff; e_in = e_ff; prob_in = prob_ff;
      second_in = second_ff; emitted_in = emitted_ff;
      ov_in = ov_ff; oc_in = oc_ff; oh_in = oh_ff; oconf_in = oconf_ff; oe_in = oe_ff;
      dreq = '0; sum_add = '0;
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               x_in = req.logit_value; eos_in = req.end_of_sequence;
               gt_in = req.logit_value > best_ff;
               state_in = S_EXP;
            end
         end
         // table lookup of the exponential
         S_EXP: begin
            e_in = (idx_full >= 18'(EXP_TABLE_DEPTH)) ? 17'd0
                   : exp_rom[idx_full[EXP_IDX_W-1:0]];
            state_in = S_MAC;
         end
         // multiply-add on the accumulator
         S_MAC: begin
            if (pos_ff == 7'd0) begin
               best_in = x_ff; cls_in = '0; acc_in = 24'd65536;
            end else if (gt_ff) begin
               sum_add = 25'(scaled) + 25'd65536;
               if (scaled > 26'(ACC_MAX) || sum_add > 25'(ACC_MAX)) acc_in = ACC_MAX;
               else acc_in = sum_add[ACC_W-1:0];
               best_in = x_ff; cls_in = pos_ff;
            end else begin
               sum_add = 25'(acc_ff) + 25'(e_ff);
               acc_in = (sum_add > 25'(ACC_MAX)) ? ACC_MAX : sum_add[ACC_W-1:0];
            end
            if (eos_ff || 8'(pos_ff) + 8'd1 >= count_eff) begin
               pos_in = '0; state_in = S_RECIP;
            end else begin
               pos_in = pos_ff + 7'd1; state_in = S_IDLE;
            end
         end
         S_RECIP: begin
            if (acc_ff == '0) begin
               prob_in = 16'hFFFF; state_in = S_RUN;
            end else begin
               dreq.start = 1'b1;
               dreq.numer = 34'h1_0000_0000 + 34'(acc_ff >> 1);
               dreq.denom = 26'(acc_ff);
               state_in = S_RWAIT;
            end
         end
         S_RWAIT: begin
            if (drsp.done) begin
               prob_in = (drsp.quot > 34'd65535) ? 16'hFFFF : drsp.quot[15:0];
               state_in = S_RUN;
            end
         end
         // run bookkeeping; a changed class closes the old run first
         S_RUN: begin
            emitted_in = 1'b0;
            if (8'(cls_ff) != prev_ff) begin
               second_in = 1'b1;
               if (have_run) state_in = S_MEAN;
               else state_in = S_EMIT;
            end else begin
               if (len_ff < RUN_W'(MAX_RUN)) begin
                  tot_in = tot_ff + TOT_W'(prob_ff); len_in = len_ff + RUN_W'(1);
               end
               second_in = 1'b0;
               state_in = eos_ff ? S_EOS : S_IDLE;
            end
         end
         // mean starts only once the output register is free
         S_MEAN: begin
            if (!ov_ff) begin
               dreq.start = 1'b1;
               dreq.numer = 34'(tot_ff) + 34'(len_ff >> 1);
               dreq.denom = 26'(len_ff);
               state_in = S_MWAIT;
            end
         end
         // a closed run is last at end of sequence when no new run follows or the new run is blank
         S_MWAIT: begin
            if (drsp.done) begin
               ov_in = 1'b1; oc_in = 7'(prev_ff - 8'd1); oh_in = 1'b1;
               oconf_in = (drsp.quot > 34'd65535) ? 16'hFFFF : drsp.quot[15:0];
               oe_in = eos_ff && (!second_ff || cls_ff == 7'd0); emitted_in = 1'b1;
               state_in = S_EMIT;
            end
         end
         // after a flush: start the new run, or finish the sequence
         S_EMIT: begin
            if (second_ff) begin
               second_in = 1'b0;
               prev_in = 8'(cls_ff); tot_in = TOT_W'(prob_ff); len_in = RUN_W'(1);
               state_in = eos_ff ? S_EOS : S_IDLE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_EOS: begin
            if (!ov_ff) begin
               if (have_run) begin
                  state_in = S_MEAN;
               end else begin
                  ov_in = 1'b1; oc_in = '0; oh_in = 1'b0; oconf_in = '0; oe_in = 1'b1;
                  if (emitted_ff) begin
                     ov_in = 1'b0; oe_in = 1'b1;
                  end
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!ov_ff || !emitted_ff || oe_ff) begin
               prev_in = NONE_MARK; tot_in = '0; len_in = '0; best_in = '0;
               cls_in = '0; acc_in = '0; pos_in = '0; emitted_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= 8'd128; best_ff <= '0; cls_ff <= '0;
         acc_ff <= '0; pos_ff <= '0; prev_ff <= NONE_MARK; tot_ff <= '0;
         len_ff <= '0; ov_ff <= 1'b0; second_ff <= 1'b0; emitted_ff <= 1'b0;
      end else begin
         state_ff <= state_in; best_ff <= best_in; cls_ff <= cls_in;
         acc_ff <= acc_in; pos_ff <= pos_in; prev_ff <= prev_in; tot_ff <= tot_in;
         len_ff <= len_in; ov_ff <= ov_in; second_ff <= second_in;
         emitted_ff <= emitted_in;
         if (csr_write_enable) count_ff <= csr_write_data;
      end
      x_ff <= x_in; eos_ff <= eos_in; gt_ff <= gt_in; e_ff <= e_in; prob_ff <= prob_in;
      oc_ff <= oc_in; oh_ff <= oh_in; oconf_ff <= oconf_in; oe_ff <= oe_in;
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = ov_ff;
   assign rsp.char_index  = oc_ff;
   assign rsp.has_char    = oh_ff;
   assign rsp.confidence  = oconf_ff;
   assign rsp.end_of_text = oe_ff;

   `CTC_ASSERT_IMP(a_ready_idle, clock, reset, req.ready, state_ff == S_IDLE, "ready outside idle")
   `CTC_ASSERT_IMP(a_nochar_zero, clock, reset, ov_ff && !oh_ff, oe_ff && oconf_ff == 16'd0, "bare item malformed")
   `CTC_ASSERT_IMP(a_len_cap, clock, reset, 1'b1, len_ff <= RUN_W'(MAX_RUN), "run length above cap")
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the streaming CTC greedy decoder
`timescale 1ns / 1ps
module tb_top;
   import ctc_pkg::*;

   localparam int LOGIT_TARGET = 1700;  // logits to send in total
   localparam int SETTLE_CYCLES = 400;  // covers three divider passes per row end
   localparam longint CYCLE_LIMIT = 6000000;

   typedef struct packed {
      logic [6:0]  char_index;
      logic        has_char;
      logic [15:0] confidence;
      logic        end_of_text;
   } token_type;

   // Decoder prediction plus expected-token store
   class ctc_decode_scoreboard;
      token_type   expected_q[$];
      int unsigned exp_lut[EXP_TABLE_DEPTH];
      int          mismatches;
      int unsigned alphabet_reg;
      longint      best_logit;
      int unsigned best_class, exp_sum, row_pos, prev_class, run_len;
      longint      run_total;

      function new();
         longint u, term, acc;
         for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            u = (longint'(i) <<< 30) / EXP_TABLE_DEPTH;
            term = longint'(1) <<< 30;
            acc = term;
            for (int k = 1; k <= 16; k++) begin
               term = ((term * u) >>> 30) / k;
               if (k % 2 == 1) acc = acc - term;
               else acc = acc + term;
            end
            if (acc < 0) acc = 0;
            if (acc > (longint'(1) <<< 30)) acc = longint'(1) <<< 30;
            for (int s = 0; s < 4; s++) acc = (acc * acc + (longint'(1) <<< 29)) >>> 30;
            exp_lut[i] = int'((acc + (1 <<< 13)) >>> 14);
         end
         mismatches = 0;
         alphabet_reg = 128;
         clear_sequence();
      endfunction

      function void clear_sequence();
         best_logit = 0;
         best_class = 0;
         exp_sum = 0;
         row_pos = 0;
         prev_class = NONE_MARK;
         run_total = 0;
         run_len = 0;
      endfunction

      function void set_alphabet(logic [7:0] v);
         alphabet_reg = v;
      endfunction

      function int unsigned exp_weight(longint d);
         longint idx;
         idx = (d * EXP_TABLE_DEPTH + 2048) / 4096;
         if (idx >= EXP_TABLE_DEPTH) return 0;
         return exp_lut[idx];
      endfunction

      function int unsigned sat_sum(longint v);
         return (v > longint'(ACC_MAX)) ? int'(ACC_MAX) : int'(v);
      endfunction

      // Emit the finished run unless it is blank or empty
      function void close_run();
         token_type t;
         longint mean;
         if (prev_class == NONE_MARK || prev_class == 0 || run_len == 0) return;
         mean = (run_total + run_len / 2) / run_len;
         if (mean > 65535) mean = 65535;
         t.char_index = 7'(prev_class - 1);
         t.has_char = 1'b1;
         t.confidence = 16'(mean);
         t.end_of_text = 1'b0;
         expected_q.push_back(t);
      endfunction

      function void note_logit(logic signed [15:0] x, logic eos);
         int unsigned cnt, p, prob, queued_at;
         longint scaled, q;
         token_type t;
         cnt = alphabet_reg;
         if (cnt < 2) cnt = 2;
         if (cnt > MAX_ALPHABET) cnt = MAX_ALPHABET;
         p = row_pos;
         queued_at = expected_q.size();
         if (p == 0) begin
            best_logit = x;
            best_class = 0;
            exp_sum = 65536;
         end else if (longint'(x) > best_logit) begin
            scaled = (longint'(exp_sum) * exp_weight(longint'(x) - best_logit) + 32768) >>> 16;
            exp_sum = sat_sum(scaled + 65536);
            best_logit = x;
            best_class = p & 7'h7f;
         end else begin
            exp_sum = sat_sum(longint'(exp_sum) + exp_weight(best_logit - longint'(x)));
         end
         // row end: reciprocal of the softmax sum, then run bookkeeping
         if (eos || p + 1 >= cnt) begin
            prob = 65535;
            row_pos = 0;
            if (exp_sum != 0) begin
               q = ((longint'(1) <<< 32) + exp_sum / 2) / exp_sum;
               prob = (q > 65535) ? 65535 : int'(q);
            end
            if (best_class != prev_class) begin
               close_run();
               prev_class = best_class;
               run_total = prob;
               run_len = 1;
            end else if (run_len < MAX_RUN) begin
               run_total += prob;
               run_len++;
            end
         end else begin
            row_pos = (p + 1) & 7'h7f;
         end
         if (eos) begin
            close_run();
            if (expected_q.size() == queued_at) begin
               t = '0;
               expected_q.push_back(t);
            end
            expected_q[expected_q.size() - 1].end_of_text = 1'b1;
            clear_sequence();
         end
      endfunction

      function void check_token(token_type got);
         token_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected token: ch=%0d has=%0b conf=%0d eot=%0b",
                        got.char_index, got.has_char, got.confidence, got.end_of_text);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("token mismatch: exp ch=%0d has=%0b conf=%0d eot=%0b, got ch=%0d has=%0b conf=%0d eot=%0b",
                        want.char_index, want.has_char, want.confidence, want.end_of_text,
                        got.char_index, got.has_char, got.confidence, got.end_of_text);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;
   bit   calm = 1'b0;       // no idling on either side while set
   longint cycle_count = 0;
   int   logits_sent = 0;

   ctc_req_if req ();
   ctc_rsp_if rsp ();
   ctc_decode_scoreboard sb = new();

   ctc_greedy_decoder_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req.sink),
      .rsp              (rsp.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Cycle watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: random stalls, check every transfer
   initial begin
      int stall;
      token_type got;
      stall = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) rsp.ready = 1'b0;
         else if (stall > 0) begin
            rsp.ready = 1'b0;
            stall--;
         end else begin
            rsp.ready = 1'b1;
            stall = gap_len();
         end
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            got.char_index = rsp.char_index;
            got.has_char = rsp.has_char;
            got.confidence = rsp.confidence;
            got.end_of_text = rsp.end_of_text;
            sb.check_token(got);
         end
      end
   end

   task automatic send_logit(logic signed [15:0] x, logic eos);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid = 1'b1;
      req.logit_value = x;
      req.end_of_sequence = eos;
      do @(posedge clock); while (!req.ready);
      sb.note_logit(x, eos);
      logits_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_alphabet(logic [7:0] v);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = v;
      @(posedge clock);
      sb.set_alphabet(v);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // One sequence: rows whose argmax follows a small class pool unless noise is set
   task automatic send_sequence(int unsigned cnt, int rows, bit noise);
      int pool_a, pool_b, tgt, stop_at;
      logic signed [15:0] x;
      bit wide;
      pool_a = $urandom_range(0, cnt - 1);
      pool_b = $urandom_range(0, cnt - 1);
      for (int r = 0; r < rows; r++) begin
         tgt = ($urandom_range(0, 2) == 0) ? pool_b : pool_a;
         wide = ($urandom_range(0, 4) == 0);
         stop_at = cnt - 1;
         if (r == rows - 1 && $urandom_range(0, 4) == 0) stop_at = $urandom_range(0, cnt - 1);
         for (int c = 0; c <= stop_at; c++) begin
            if (noise) x = 16'($urandom);
            else if (c == tgt) x = wide ? 16'sd32767 : 16'(1100 + $urandom_range(0, 900));
            else if (wide) x = 16'($urandom);
            else x = 16'(int'($urandom_range(0, 2100)) - 1024);
            if (wide && c != tgt && x == 16'sd32767) x = 16'sd0;
            send_logit(x, r == rows - 1 && c == stop_at);
         end
      end
   endtask

   initial begin
      int unsigned cnt;
      int sel;
      logic [7:0] wval;
      req.valid = 1'b0;
      req.logit_value = '0;
      req.end_of_sequence = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: three classes per row
      write_alphabet(8'd3);
      send_logit(16'sh8000, 1'b1);   // lone logit at end of sequence: bare end item
      send_logit(-16'sd32768, 1'b0); // row argmax 1, extreme logits
      send_logit(16'sd32767, 1'b0);
      send_logit(16'sd0, 1'b0);
      send_logit(16'sd10, 1'b0);     // same argmax again: run grows
      send_logit(16'sd20, 1'b0);
      send_logit(16'sd5, 1'b0);
      send_logit(16'sd7, 1'b0);      // tie row: first class wins, blank
      send_logit(16'sd7, 1'b0);
      send_logit(16'sd7, 1'b0);
      send_logit(16'sd0, 1'b0);      // argmax 2
      send_logit(16'sd100, 1'b0);
      send_logit(16'sd300, 1'b0);
      send_logit(16'sd0, 1'b0);      // partial row at end: argmax 1, two results
      send_logit(16'sd256, 1'b1);
      send_logit(16'sd500, 1'b0);    // blank only sequence
      send_logit(-16'sd500, 1'b0);
      send_logit(16'sd499, 1'b1);
      drain();

      // Random phases with different alphabet sizes
      while (logits_sent < LOGIT_TARGET) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) wval = 8'd0;
         else if (sel == 1) wval = 8'd1;
         else if (sel == 2) wval = 8'd255;
         else if (sel == 3) wval = 8'd128;
         else if (sel == 4) wval = 8'($urandom_range(2, 128));
         else wval = 8'($urandom_range(2, 8));
         write_alphabet(wval);
         cnt = (wval < 2) ? 2 : (wval > MAX_ALPHABET ? MAX_ALPHABET : wval);
         calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 4))
            send_sequence(cnt, (cnt > 16) ? $urandom_range(1, 2) : $urandom_range(1, 7),
                          $urandom_range(0, 6) == 0);
         drain();
      end
      calm = 1'b0;

      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
